[rtl/python_source_line_classifier_macros.svh]
// ----------------------------------------------------------------------------
// Python source line classifier: assertion macros
// Concurrent assertion helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PYTHON_SOURCE_LINE_CLASSIFIER_MACROS_SVH
`define PYTHON_SOURCE_LINE_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define PSLC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define PSLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PSLC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PSLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/pslc_pkg.sv]
// ----------------------------------------------------------------------------
// Python source line classifier: package
// Word types, lexer mode codes, character constants and the byte scanner.
// ----------------------------------------------------------------------------
package pslc_pkg;

    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_SINGLE     = 3'd1;
    localparam logic [2:0] MODE_DOUBLE     = 3'd2;
    localparam logic [2:0] MODE_TRI_SINGLE = 3'd3;
    localparam logic [2:0] MODE_TRI_DOUBLE = 3'd4;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    localparam logic EVT_SUMMARY = 1'b0;
    localparam logic EVT_COMMENT = 1'b1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } t_in;

    typedef struct packed {
        logic        event_kind;
        logic [31:0] line_number;
        logic [15:0] column;
        logic        line_blank;
        logic        line_code;
        logic        line_comment;
        logic [31:0] physical_total;
        logic [31:0] blank_total;
        logic [31:0] code_total;
        logic [31:0] comment_total;
        logic [31:0] mixed_total;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [2:0] mode;
        logic       esc;
        logic       code;
        logic       comm;
    } t_lex;

    typedef struct packed {
        t_lex st;
        logic three;   // a triple quote was taken, three bytes consumed
        logic hit;     // comment start found
    } t_scan;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Scan one byte in the given lexer state; tri_q says the next two bytes match it.
    function automatic t_scan scan_byte(input t_lex st, input logic [7:0] c,
                                        input logic tri_q);
        t_scan      r;
        logic [7:0] q;
        r.st    = st;
        r.three = 1'b0;
        r.hit   = 1'b0;
        q       = CH_SQUOTE;
        case (st.mode)
            MODE_TRI_SINGLE, MODE_TRI_DOUBLE: begin
                r.st.code = 1'b1;
                q = (st.mode == MODE_TRI_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
                if (tri_q && (c == q)) begin
                    r.st.mode = MODE_NORMAL;
                    r.three   = 1'b1;
                end
            end
            MODE_SINGLE, MODE_DOUBLE: begin
                r.st.code = 1'b1;
                q = (st.mode == MODE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
                if (st.esc) begin
                    r.st.esc = 1'b0;
                end else if (c == CH_BSLASH) begin
                    r.st.esc = 1'b1;
                end else if (c == q) begin
                    r.st.mode = MODE_NORMAL;
                end
            end
            default: begin
                if (c == CH_HASH) begin
                    r.st.comm = 1'b1;
                    r.hit     = 1'b1;
                end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
                    r.st.code = 1'b1;
                    if (tri_q) begin
                        r.st.mode = (c == CH_SQUOTE) ? MODE_TRI_SINGLE : MODE_TRI_DOUBLE;
                        r.three   = 1'b1;
                    end else begin
                        r.st.esc  = 1'b0;
                        r.st.mode = (c == CH_SQUOTE) ? MODE_SINGLE : MODE_DOUBLE;
                    end
                end else if (!is_space(c)) begin
                    r.st.code = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

endpackage

[rtl/python_source_line_classifier.sv]
// ----------------------------------------------------------------------------
// Python source line classifier
// Lexes Python source a byte at a time, reports comments and classifies lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_stall, i_data): one word per source byte, or a
//   word with line_end set that closes the current physical line.
//   Output channel (o_valid/i_stall, o_data): comment events and line
//   summaries with running saturating totals; last_of_run marks the final
//   word caused by one input word.
//   Path: a word is registered at acceptance and its results enter the
//   two-entry output queue once the word commits; results are offered
//   from the head of that queue.
//   Throughput: one input word per cycle while o_stall is low. The output
//   port moves one result per cycle while i_stall is low, so a line end
//   that also reports a comment sends two result words through it.
//   Reset: lexer returns to normal mode, line and class counts clear, the
//   output queue empties.
//   Stall: while i_stall is high the queue holds; once it cannot take the
//   results of the registered word, o_stall rises and input is held off.
// ----------------------------------------------------------------------------
`include "python_source_line_classifier_macros.svh"

module python_source_line_classifier
    import pslc_pkg::*;
#(
    parameter int COUNT_BITS  = 32,
    parameter int COLUMN_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

    // input register
    logic                   r_in_vld;
    t_in                    r_in;

    // lexer state
    logic [2:0]             r_mode;
    logic                   r_esc;
    logic                   r_fcode;
    logic                   r_fcomm;
    logic                   r_fnonsp;
    logic                   r_fbegan;
    logic [7:0]             r_la0;
    logic [7:0]             r_la1;
    logic [1:0]             r_la_cnt;
    logic                   r_ric;
    logic [31:0]            r_line;
    logic [COLUMN_BITS-1:0] r_col;
    logic [COUNT_BITS-1:0]  r_tot [5];

    // output queue
    t_out                   r_q [2];
    logic [1:0]             r_qn;
    t_out                   n_q [2];
    logic [1:0]             n_qn;

    logic                   pop;
    logic [1:0]             free;
    logic [1:0]             nres;
    logic                   commit;

    logic [7:0]             c;
    logic                   le;
    t_lex                   cur;
    logic                   tri_hit;
    logic                   do1;
    logic                   do2;
    t_scan                  s1;
    t_scan                  s2;
    t_lex                   st1;
    t_lex                   st2;
    logic                   hit1;
    logic                   hit2;
    logic                   hit;
    logic [COLUMN_BITS+1:0] col_sum;
    logic [COLUMN_BITS-1:0] col1;
    logic [COLUMN_BITS-1:0] cmt_col;
    logic [2:0]             mode_e;
    logic                   blank;
    logic                   code_l;
    logic                   comm_l;
    logic [4:0]             tot_inc;
    logic [COUNT_BITS-1:0]  tot_upd [5];
    logic [31:0]            line_next;
    t_out                   cmt_w;
    t_out                   sum_w;
    t_out                   res0;
    t_out                   res1;

    // --------------------------------------------------------------------
    // lexer step on the registered word
    // --------------------------------------------------------------------
    always_comb begin
        c       = r_in.char_code;
        le      = r_in.line_end;
        cur     = '{mode: r_mode, esc: r_esc, code: r_fcode, comm: r_fcomm};
        tri_hit = !le && (r_la1 == r_la0) && (c == r_la0);

        // oldest byte of the window scans once its two successors are known,
        // or at line end with whatever lookahead there is
        do1  = !r_ric && (le ? (r_la_cnt != 2'd0) : (r_la_cnt == 2'd2));
        s1   = scan_byte(cur, r_la0, tri_hit);
        st1  = do1 ? s1.st : cur;
        hit1 = do1 && s1.hit;

        col_sum = {2'b00, r_col} + (s1.three ? (COLUMN_BITS+2)'(3) : (COLUMN_BITS+2)'(1));
        if (!do1) begin
            col1 = r_col;
        end else if (col_sum > {2'b00, COL_MAX}) begin
            col1 = COL_MAX;
        end else begin
            col1 = col_sum[COLUMN_BITS-1:0];
        end

        do2  = le && (r_la_cnt == 2'd2) && !r_ric && !s1.hit;
        s2   = scan_byte(st1, r_la1, 1'b0);
        st2  = do2 ? s2.st : st1;
        hit2 = do2 && s2.hit;

        hit     = hit1 || hit2;
        cmt_col = hit1 ? r_col : col1;

        // close short strings at line end
        mode_e = ((st2.mode == MODE_SINGLE) || (st2.mode == MODE_DOUBLE)) ?
                 MODE_NORMAL : st2.mode;
        blank  = r_fbegan && !r_fnonsp;
        code_l = !blank && (st2.code || (mode_e == MODE_TRI_SINGLE) ||
                            (mode_e == MODE_TRI_DOUBLE));
        comm_l = !blank && st2.comm;

        tot_inc = {code_l && comm_l, comm_l, code_l, blank, 1'b1};
        for (int i = 0; i < 5; i++) begin
            tot_upd[i] = (tot_inc[i] && (r_tot[i] != {COUNT_BITS{1'b1}})) ?
                         r_tot[i] + COUNT_BITS'(1) : r_tot[i];
        end

        line_next = (r_line == 32'hFFFF_FFFF) ? r_line : r_line + 32'd1;

        cmt_w             = '0;
        cmt_w.event_kind  = EVT_COMMENT;
        cmt_w.line_number = line_next;
        cmt_w.column      = 16'(cmt_col);
        cmt_w.last_of_run = !le;

        sum_w                = '0;
        sum_w.event_kind     = EVT_SUMMARY;
        sum_w.line_number    = line_next;
        sum_w.line_blank     = blank;
        sum_w.line_code      = code_l;
        sum_w.line_comment   = comm_l;
        sum_w.physical_total = 32'(tot_upd[0]);
        sum_w.blank_total    = 32'(tot_upd[1]);
        sum_w.code_total     = 32'(tot_upd[2]);
        sum_w.comment_total  = 32'(tot_upd[3]);
        sum_w.mixed_total    = 32'(tot_upd[4]);
        sum_w.last_of_run    = 1'b1;

        res0 = hit ? cmt_w : sum_w;
        res1 = sum_w;
        if (le) begin
            nres = hit ? 2'd2 : 2'd1;
        end else begin
            nres = hit ? 2'd1 : 2'd0;
        end
    end

    // --------------------------------------------------------------------
    // handshake and output queue
    // --------------------------------------------------------------------
    assign o_valid = (r_qn != 2'd0);
    assign o_data  = r_q[0];
    assign pop     = o_valid && !i_stall;
    assign free    = 2'd2 - r_qn + {1'b0, pop};
    assign commit  = r_in_vld && (free >= nres);
    assign o_stall = r_in_vld && !commit;

    always_comb begin
        n_q  = r_q;
        n_qn = r_qn;
        if (pop) begin
            n_q[0] = r_q[1];
            n_qn   = r_qn - 2'd1;
        end
        if (commit) begin
            if (n_qn == 2'd0) begin
                n_q[0] = res0;
                n_q[1] = res1;
            end else if (n_qn == 2'd1) begin
                n_q[1] = res0;
            end
            n_qn = n_qn + nres;
        end
    end

    // --------------------------------------------------------------------
    // control state
    // --------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_qn     <= 2'd0;
            r_mode   <= MODE_NORMAL;
            r_esc    <= 1'b0;
            r_fcode  <= 1'b0;
            r_fcomm  <= 1'b0;
            r_fnonsp <= 1'b0;
            r_fbegan <= 1'b1;
            r_la_cnt <= 2'd0;
            r_ric    <= 1'b0;
            r_line   <= '0;
            r_col    <= '0;
            for (int i = 0; i < 5; i++) begin
                r_tot[i] <= '0;
            end
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            r_qn <= n_qn;
            if (commit) begin
                if (le) begin
                    r_mode   <= mode_e;
                    r_esc    <= 1'b0;
                    r_fcode  <= 1'b0;
                    r_fcomm  <= 1'b0;
                    r_fnonsp <= 1'b0;
                    r_fbegan <= (mode_e == MODE_NORMAL) || (mode_e > MODE_TRI_DOUBLE);
                    r_la_cnt <= 2'd0;
                    r_ric    <= 1'b0;
                    r_col    <= '0;
                    r_line   <= line_next;
                    for (int i = 0; i < 5; i++) begin
                        r_tot[i] <= tot_upd[i];
                    end
                end else begin
                    r_mode   <= st1.mode;
                    r_esc    <= st1.esc;
                    r_fcode  <= st1.code;
                    r_fcomm  <= st1.comm;
                    r_fnonsp <= r_fnonsp || !is_space(c);
                    r_ric    <= r_ric || hit1;
                    r_col    <= col1;
                    if (!r_ric) begin
                        if (r_la_cnt != 2'd2) begin
                            r_la_cnt <= r_la_cnt + 2'd1;
                        end else if (s1.three) begin
                            r_la_cnt <= 2'd0;
                        end
                    end
                end
            end
        end
    end

    // payload: input word, lookahead window, queue entries
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in <= i_data;
        end
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
        if (commit && !le && !r_ric) begin
            if (r_la_cnt == 2'd0) begin
                r_la0 <= c;
            end else if (r_la_cnt == 2'd1) begin
                r_la1 <= c;
            end else if (!s1.three) begin
                // advance the window by one byte
                r_la0 <= r_la1;
                r_la1 <= c;
            end
        end
    end

    // --------------------------------------------------------------------
    // assertions
    // --------------------------------------------------------------------
    `PSLC_ASSERT_SAME(a_queue_depth, i_clk, i_rst_n, 1'b1, r_qn != 2'd3, "queue overfilled")
    `PSLC_ASSERT_SAME(a_window_depth, i_clk, i_rst_n, 1'b1, r_la_cnt != 2'd3, "lookahead overfilled")
    `PSLC_ASSERT_SAME(a_comment_then_summary, i_clk, i_rst_n, (r_qn == 2'd2) && (r_q[0].event_kind == EVT_COMMENT), r_q[1].event_kind == EVT_SUMMARY, "comment not followed by summary")
    `PSLC_ASSERT_SAME(a_summary_last, i_clk, i_rst_n, o_valid && (o_data.event_kind == EVT_SUMMARY), o_data.last_of_run, "summary not last of run")
    `PSLC_ASSERT_NEXT(a_line_end_resets, i_clk, i_rst_n, commit && le, (r_la_cnt == 2'd0) && !r_ric && (r_col == '0), "line state not cleared at line end")

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Python source line classifier: testbench
// Streams Python-like source bytes and line ends into the classifier, works out
// the comment events and line summaries independently, and checks every result
// word field by field under random idling and backpressure on both sides.
// ----------------------------------------------------------------------------
module tb;
    import pslc_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 200;
    localparam int WORD_TARGET = 1030;
    localparam int CALM_TAIL   = 150;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic src_valid = 1'b0;
    t_in  src_word  = '0;
    logic res_stall = 1'b0;
    logic src_stall;
    logic res_valid;
    t_out res_word;

    // lexer and line state of the predictor
    logic [2:0]  lx_mode;
    logic        lx_esc;
    logic [7:0]  la_byte [2];
    int          la_cnt;
    logic        skip_rest;
    logic        seen_code;
    logic        seen_comment;
    logic        seen_nonspace;
    logic        began_normal;
    logic [31:0] line_no;
    logic [15:0] col_no;
    logic [31:0] totals [5];
    t_out        step_rows [$];
    t_out        expected_q [$];

    int fail_count  = 0;
    int words_sent  = 0;
    int quiet       = 0;
    int hold_asked  = 0;
    int hold_seen   = 0;
    int sink_left   = 0;
    bit src_idle    = 1'b1;
    bit sink_idle   = 1'b1;

    python_source_line_classifier u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (src_valid),
        .o_stall (src_stall),
        .i_data  (src_word),
        .o_valid (res_valid),
        .i_stall (res_stall),
        .o_data  (res_word)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Line classification predictor
    // ------------------------------------------------------------------------
    function automatic logic white_byte(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [31:0] inc_sat(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void adv_col(int n);
        int sum;
        sum    = int'(col_no) + n;
        col_no = (sum > 32'h0000_FFFF) ? 16'hFFFF : sum[15:0];
    endfunction

    function automatic void open_line();
        lx_esc        = 1'b0;
        la_byte[0]    = 8'h00;
        la_byte[1]    = 8'h00;
        la_cnt        = 0;
        skip_rest     = 1'b0;
        col_no        = '0;
        seen_code     = 1'b0;
        seen_comment  = 1'b0;
        seen_nonspace = 1'b0;
        began_normal  = (lx_mode == MODE_NORMAL) || (lx_mode > MODE_TRI_DOUBLE);
    endfunction

    function automatic void reset_lexer();
        lx_mode = MODE_NORMAL;
        line_no = '0;
        foreach (totals[i]) totals[i] = '0;
        open_line();
    endfunction

    // Lex one byte with up to two following bytes known; return bytes consumed.
    function automatic int lex_byte(logic [7:0] c, int avail, logic [7:0] n1,
                                    logic [7:0] n2);
        logic       triple;
        logic [7:0] q;
        t_out       r;
        triple = (avail >= 2) && (n1 == c) && (n2 == c);
        case (lx_mode)
            MODE_TRI_SINGLE, MODE_TRI_DOUBLE: begin
                seen_code = 1'b1;
                q = (lx_mode == MODE_TRI_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
                if (triple && (c == q)) begin
                    lx_mode = MODE_NORMAL;
                    return 3;
                end
            end
            MODE_SINGLE, MODE_DOUBLE: begin
                seen_code = 1'b1;
                q = (lx_mode == MODE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
                if (lx_esc) begin
                    lx_esc = 1'b0;
                end else if (c == CH_BSLASH) begin
                    lx_esc = 1'b1;
                end else if (c == q) begin
                    lx_mode = MODE_NORMAL;
                end
            end
            default: begin
                if (c == CH_HASH) begin
                    seen_comment  = 1'b1;
                    skip_rest     = 1'b1;
                    r             = '0;
                    r.event_kind  = EVT_COMMENT;
                    r.line_number = inc_sat(line_no);
                    r.column      = col_no;
                    step_rows.insert(step_rows.size(), r);
                end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
                    seen_code = 1'b1;
                    if (triple) begin
                        lx_mode = (c == CH_SQUOTE) ? MODE_TRI_SINGLE : MODE_TRI_DOUBLE;
                        return 3;
                    end
                    lx_esc  = 1'b0;
                    lx_mode = (c == CH_SQUOTE) ? MODE_SINGLE : MODE_DOUBLE;
                end else if (!white_byte(c)) begin
                    seen_code = 1'b1;
                end
            end
        endcase
        return 1;
    endfunction

    function automatic void close_line();
        int   n;
        logic blank;
        logic code;
        logic comm;
        t_out r;
        // flush the lookahead with nothing known beyond the line end
        if ((la_cnt >= 1) && !skip_rest) begin
            n = lex_byte(la_byte[0], la_cnt - 1, la_byte[1], 8'h00);
            adv_col(n);
            if ((la_cnt == 2) && (n == 1) && !skip_rest)
                void'(lex_byte(la_byte[1], 0, 8'h00, 8'h00));
        end
        if ((lx_mode == MODE_SINGLE) || (lx_mode == MODE_DOUBLE))
            lx_mode = MODE_NORMAL;
        blank = began_normal && !seen_nonspace;
        code  = !blank && (seen_code || (lx_mode == MODE_TRI_SINGLE) ||
                           (lx_mode == MODE_TRI_DOUBLE));
        comm  = !blank && seen_comment;
        totals[0] = inc_sat(totals[0]);
        if (blank) totals[1] = inc_sat(totals[1]);
        if (code) totals[2] = inc_sat(totals[2]);
        if (comm) totals[3] = inc_sat(totals[3]);
        if (code && comm) totals[4] = inc_sat(totals[4]);
        line_no = inc_sat(line_no);
        r                = '0;
        r.event_kind     = EVT_SUMMARY;
        r.line_number    = line_no;
        r.line_blank     = blank;
        r.line_code      = code;
        r.line_comment   = comm;
        r.physical_total = totals[0];
        r.blank_total    = totals[1];
        r.code_total     = totals[2];
        r.comment_total  = totals[3];
        r.mixed_total    = totals[4];
        step_rows.insert(step_rows.size(), r);
        open_line();
    endfunction

    function automatic void predict_word(t_in w);
        int   n;
        t_out r;
        step_rows.delete();
        if (w.line_end) begin
            close_line();
        end else begin
            if (!white_byte(w.char_code)) seen_nonspace = 1'b1;
            if (!skip_rest) begin
                if (la_cnt < 2) begin
                    la_byte[la_cnt[0]] = w.char_code;
                    la_cnt++;
                end else begin
                    n = lex_byte(la_byte[0], 2, la_byte[1], w.char_code);
                    adv_col(n);
                    if (n == 3) begin
                        la_cnt = 0;
                    end else begin
                        la_byte[0] = la_byte[1];
                        la_byte[1] = w.char_code;
                    end
                end
            end
        end
        if (step_rows.size() > 0) begin
            r = step_rows[step_rows.size() - 1];
            r.last_of_run = 1'b1;
            step_rows[step_rows.size() - 1] = r;
        end
        foreach (step_rows[k]) expected_q.insert(expected_q.size(), step_rows[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk) begin : check_results
        t_out want;
        if (rst_n && res_valid && !res_stall) begin
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected, line_number %0d",
                       res_word.line_number);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("event_kind", 32'(want.event_kind),
                            32'(res_word.event_kind));
                check_field("line_number", want.line_number, res_word.line_number);
                check_field("column", 32'(want.column), 32'(res_word.column));
                check_field("line_blank", 32'(want.line_blank),
                            32'(res_word.line_blank));
                check_field("line_code", 32'(want.line_code),
                            32'(res_word.line_code));
                check_field("line_comment", 32'(want.line_comment),
                            32'(res_word.line_comment));
                check_field("physical_total", want.physical_total,
                            res_word.physical_total);
                check_field("blank_total", want.blank_total, res_word.blank_total);
                check_field("code_total", want.code_total, res_word.code_total);
                check_field("comment_total", want.comment_total, res_word.comment_total);
                check_field("mixed_total", want.mixed_total, res_word.mixed_total);
                check_field("last_of_run", 32'(want.last_of_run),
                            32'(res_word.last_of_run));
            end
        end
    end

    always @(posedge clk) begin
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            sink_left = LONG_HOLD;
        end else if ((sink_left == 0) && sink_idle && ($urandom_range(0, 7) == 0)) begin
            sink_left = $urandom_range(1, 19);
        end
        if (sink_left != 0) begin
            res_stall <= 1'b1;
            sink_left--;
        end else begin
            res_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((src_valid && !src_stall) || (res_valid && !res_stall)) begin
                quiet = 0;
            end else if (++quiet >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic send_word(t_in w);
        if (src_idle && ($urandom_range(0, 9) == 0)) begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= w;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        predict_word(w);
        words_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        t_in w;
        w.char_code = b;
        w.line_end  = 1'b0;
        send_word(w);
    endtask

    task automatic end_line();
        t_in w;
        w.char_code = 8'($urandom_range(0, 255));   // ignored on a line end
        w.line_end  = 1'b1;
        send_word(w);
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    task automatic send_line(string s);
        send_text(s);
        end_line();
    endtask

    // drop valid and hold until every expected word has arrived
    task automatic wait_drain();
        src_valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
    endtask

    function automatic logic [7:0] space_byte();
        logic [7:0] v;
        v = 8'($urandom_range(8'h09, 8'h0E));
        return (v == 8'h0E) ? 8'h20 : v;
    endfunction

    task automatic send_token();
        case ($urandom_range(0, 11))
            0, 1: repeat ($urandom_range(1, 4)) send_byte(8'(8'h61 + $urandom_range(0, 25)));
            2: send_byte(space_byte());
            3: send_byte(CH_SQUOTE);
            4: send_byte(CH_DQUOTE);
            5: repeat (3) send_byte(CH_SQUOTE);
            6: repeat (3) send_byte(CH_DQUOTE);
            7: send_byte(CH_BSLASH);
            8: send_byte(CH_HASH);
            9: send_byte(8'($urandom_range(0, 255)));
            10: send_text("'a\\'b'");
            default: send_text(" = 1");
        endcase
    endtask

    task automatic send_random_line();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind == 1) begin
            repeat ($urandom_range(1, 6)) send_byte(space_byte());
        end else if (kind == 2) begin
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
        end else if (kind != 0) begin
            repeat ($urandom_range(1, 8)) send_token();
        end
        end_line();
    endtask

    task automatic test_blank_lines();
        end_line();
        for (int b = 8'h09; b <= 8'h0D; b++) send_byte(8'(b));
        send_byte(8'h20);
        end_line();
        send_byte(8'h08);
        end_line();
        send_text("  ");
        send_byte(8'h0E);
        end_line();
    endtask

    task automatic test_code_and_comments();
        send_line("x = 1");
        send_line("#");
        send_line("# only a note");
        send_line("a = 1  # note");
        send_line("a#");
        send_line("  #");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        end_line();
    endtask

    task automatic test_short_strings();
        send_line("s = 'it\\'s' # c");
        send_line("\"a#b\"");
        send_line("'never closed # no");
        send_line("x");
        send_line("\"\\\\\"#");
        send_line("''");
        send_line("\"");
    endtask

    task automatic test_triple_quotes();
        send_line("d = \"\"\"doc # not a note");
        send_line("   ");
        end_line();
        send_line("''' still inside");
        send_line("\\\"\"\" # after");
        send_line("'''one'''");
        send_line("\"\"\"");
        send_line("\"\"\"");
        send_line("''");
        send_line("'");
    endtask

    // receiver holds off while the sender keeps offering, then the sender pauses
    task automatic test_backpressure();
        src_idle = 1'b0;
        hold_asked++;
        repeat (12) send_random_line();
        wait_drain();
        src_idle = 1'b1;
    endtask

    task automatic test_random_source();
        int start;
        int lines;
        start = words_sent;
        lines = 0;
        while (words_sent - start < WORD_TARGET) begin
            if (words_sent - start >= WORD_TARGET - CALM_TAIL) begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end else if (lines % 25 == 0) begin
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 2) == 0) wait_drain();
            end
            send_random_line();
            lines++;
        end
    endtask

    initial begin
        reset_lexer();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_blank_lines();
        test_code_and_comments();
        test_short_strings();
        test_triple_quotes();
        test_backpressure();
        test_random_source();
        wait_drain();
        repeat (20) @(posedge clk);
        if (expected_q.size() != 0) begin
            $error("%0d expected result words never arrived", expected_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
